/* design/clx_pkg.sv */
// Shared types, codes and character helpers for the configuration text lexer.
package clx_pkg;

    // Token kinds as seen on the result channel
    typedef enum logic [3:0] {
        TK_INVALID  = 4'd0,
        TK_IDENT    = 4'd1,
        TK_TRUE     = 4'd2,
        TK_FALSE    = 4'd3,
        TK_NUMBER   = 4'd4,
        TK_EQUAL    = 4'd5,
        TK_LBRACE   = 4'd6,
        TK_RBRACE   = 4'd7,
        TK_LBRACKET = 4'd8,
        TK_RBRACKET = 4'd9,
        TK_NEWLINE  = 4'd10
    } t_tok_kind;

    // What the lexer holds open between bytes
    typedef enum logic [1:0] {
        PK_NONE  = 2'd0,
        PK_RUN   = 2'd1,
        PK_QUOTE = 2'd2,
        PK_DASH  = 2'd3
    } t_pend;

    localparam int StartBits = 16;

    typedef struct packed {
        t_tok_kind              kind;
        logic [StartBits-1:0]   start;
        logic                   last;
    } t_token;

    // Up to two tokens produced by one byte, handed from front to queue
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    // Keyword tracker: letters seen (capped at five) and candidates still alive
    typedef struct packed {
        logic [2:0] prog;
        logic [1:0] cand;
    } t_kw;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [7:0] ChDash    = 8'h2D;
    localparam logic [7:0] ChDot     = 8'h2E;
    localparam logic [7:0] ChQuote   = 8'h22;
    localparam logic [7:0] ChEqual   = 8'h3D;
    localparam logic [7:0] ChLBrace  = 8'h7B;
    localparam logic [7:0] ChRBrace  = 8'h7D;
    localparam logic [7:0] ChLBrack  = 8'h5B;
    localparam logic [7:0] ChRBrack  = 8'h5D;
    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChSpace   = 8'h20;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic [7:0] true_char(input logic [2:0] k);
        logic [7:0] c;
        unique case (k)
            3'd0:    c = 8'h74; // t
            3'd1:    c = 8'h72; // r
            3'd2:    c = 8'h75; // u
            3'd3:    c = 8'h65; // e
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] false_char(input logic [2:0] k);
        logic [7:0] c;
        unique case (k)
            3'd0:    c = 8'h66; // f
            3'd1:    c = 8'h61; // a
            3'd2:    c = 8'h6C; // l
            3'd3:    c = 8'h73; // s
            3'd4:    c = 8'h65; // e
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Advance the keyword tracker by one letter
    function automatic t_kw kw_track(input t_kw kw, input logic [7:0] b);
        t_kw r;
        r = kw;
        if (kw.prog < 3'd4 && b != true_char(kw.prog)) r.cand[0] = 1'b0;
        if (kw.prog < 3'd5 && b != false_char(kw.prog)) r.cand[1] = 1'b0;
        if (kw.prog < 3'd5) r.prog = kw.prog + 3'd1;
        return r;
    endfunction

    function automatic t_tok_kind run_kind(input t_kw kw);
        t_tok_kind k;
        if (kw.cand[0] && kw.prog >= 3'd4) k = TK_TRUE;
        else if (kw.cand[1] && kw.prog >= 3'd5) k = TK_FALSE;
        else k = TK_IDENT;
        return k;
    endfunction

    // Append a token in the next free slot; a third one is dropped
    function automatic t_push add_tok(input t_push p, input t_tok_kind kind,
                                      input logic [StartBits-1:0] start);
        t_push r;
        r = p;
        if (p.cnt == 2'd0) begin
            r.tok0 = '{kind: kind, start: start, last: 1'b0};
            r.cnt  = 2'd1;
        end else if (p.cnt == 2'd1) begin
            r.tok1 = '{kind: kind, start: start, last: 1'b0};
            r.cnt  = 2'd2;
        end
        return r;
    endfunction

endpackage

/* design/clx_in_if.sv */
// Byte channel into the lexer.
interface clx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source(output valid, output data_byte, output end_of_text, input ready);
    modport sink(input valid, input data_byte, input end_of_text, output ready);
endinterface

/* design/clx_out_if.sv */
// Token channel out of the lexer.
interface clx_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] start_offset;
    logic        last_of_run;

    modport source(output valid, output token_kind, output start_offset,
                   output last_of_run, input ready);
    modport sink(input valid, input token_kind, input start_offset,
                 input last_of_run, output ready);
endinterface

/* design/clx_front.sv */
// Front end: takes bytes, keeps the lexer state and emits zero to two tokens per byte.
module clx_front
    import clx_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clx_in_if.sink      i_in,
    input  logic        i_room,
    output t_push       o_push
);

    localparam logic [OFFSET_BITS-1:0] PosMax   = '1;
    localparam logic [OFFSET_BITS-1:0] ClampLim = OFFSET_BITS'(17'h0FFFF);

    logic                   r_num;
    t_pend                  r_pend;
    logic [OFFSET_BITS-1:0] r_pstart;
    t_kw                    r_kw;
    logic [OFFSET_BITS-1:0] r_pos;

    logic                   n_num;
    t_pend                  n_pend;
    logic [OFFSET_BITS-1:0] n_pstart;
    t_kw                    n_kw;
    logic [OFFSET_BITS-1:0] n_pos;

    logic       accept;
    logic       fresh;
    logic [7:0] b;
    logic       eot;
    t_push      push;

    function automatic logic [StartBits-1:0] clamp(input logic [OFFSET_BITS-1:0] v);
        logic [StartBits-1:0] r;
        if (v > ClampLim) r = '1;
        else r = StartBits'(v);
        return r;
    endfunction

    assign b          = i_in.data_byte;
    assign eot        = i_in.end_of_text;
    assign i_in.ready = i_room;
    assign accept     = i_in.valid && i_room;

    always_comb begin
        n_num    = r_num;
        n_pend   = r_pend;
        n_pstart = r_pstart;
        n_kw     = r_kw;
        n_pos    = r_pos;
        fresh    = 1'b1;
        push     = '0;

        // close or extend whatever is open
        unique case (r_pend)
            PK_RUN: begin
                if (is_letter(b)) begin
                    n_kw  = kw_track(r_kw, b);
                    fresh = 1'b0;
                end else begin
                    push   = add_tok(push, run_kind(r_kw), clamp(r_pstart));
                    n_pend = PK_NONE;
                end
            end
            PK_QUOTE: begin
                if (is_letter(b) || is_digit(b) || b == ChSpace) begin
                    fresh = 1'b0;
                end else if (b == ChQuote) begin
                    push   = add_tok(push, TK_IDENT, clamp(r_pstart));
                    n_pend = PK_NONE;
                    fresh  = 1'b0;
                end else begin
                    push   = add_tok(push, TK_INVALID, clamp(r_pstart));
                    n_pend = PK_NONE;
                end
            end
            PK_DASH: begin
                if (is_digit(b)) begin
                    push  = add_tok(push, TK_NUMBER, clamp(r_pstart));
                    n_num = 1'b1;
                    fresh = 1'b0;
                end else begin
                    push = add_tok(push, TK_INVALID, clamp(r_pstart));
                end
                n_pend = PK_NONE;
            end
            PK_NONE: begin
            end
        endcase

        if (fresh) begin
            priority if (is_letter(b)) begin
                n_pend   = PK_RUN;
                n_pstart = r_pos;
                n_kw     = kw_track('{prog: 3'd0, cand: 2'b11}, b);
            end else if (is_digit(b)) begin
                if (!n_num) begin
                    push  = add_tok(push, TK_NUMBER, clamp(r_pos));
                    n_num = 1'b1;
                end
            end else begin
                unique case (b)
                    ChDot: begin
                        if (!n_num) push = add_tok(push, TK_INVALID, clamp(r_pos));
                    end
                    ChDash: begin
                        n_pend   = PK_DASH;
                        n_pstart = r_pos;
                    end
                    ChQuote: begin
                        n_pend   = PK_QUOTE;
                        n_pstart = r_pos;
                    end
                    ChEqual:  push = add_tok(push, TK_EQUAL, clamp(r_pos));
                    ChLBrace: push = add_tok(push, TK_LBRACE, clamp(r_pos));
                    ChRBrace: push = add_tok(push, TK_RBRACE, clamp(r_pos));
                    ChLBrack: push = add_tok(push, TK_LBRACKET, clamp(r_pos));
                    ChRBrack: push = add_tok(push, TK_RBRACKET, clamp(r_pos));
                    ChNewline: begin
                        n_num = 1'b0;
                        push  = add_tok(push, TK_NEWLINE, clamp(r_pos));
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (eot) begin
            // flush and start a new text at offset zero
            if (n_pend == PK_RUN) push = add_tok(push, run_kind(n_kw), clamp(n_pstart));
            else if (n_pend != PK_NONE) push = add_tok(push, TK_INVALID, clamp(n_pstart));
            n_num    = 1'b0;
            n_pend   = PK_NONE;
            n_pstart = '0;
            n_kw     = '{prog: 3'd0, cand: 2'b11};
            n_pos    = '0;
        end else if (r_pos != PosMax) begin
            n_pos = r_pos + OFFSET_BITS'(1);
        end

        if (push.cnt == 2'd1) push.tok0.last = 1'b1;
        if (push.cnt == 2'd2) push.tok1.last = 1'b1;
        if (!accept) push.cnt = 2'd0;
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num    <= 1'b0;
            r_pend   <= PK_NONE;
            r_pstart <= '0;
            r_kw     <= '{prog: 3'd0, cand: 2'b11};
            r_pos    <= '0;
        end else if (accept) begin
            r_num    <= n_num;
            r_pend   <= n_pend;
            r_pstart <= n_pstart;
            r_kw     <= n_kw;
            r_pos    <= n_pos;
        end
    end

endmodule

/* design/clx_queue.sv */
// Token queue between front and back: two writes and one read per cycle.
module clx_queue
    import clx_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_room,
    output logic   o_valid,
    output t_token o_tok,
    input  logic   i_pop
);

    t_token             r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr;
    logic [QPtrW-1:0]   r_rd;
    logic [QCntW-1:0]   r_cnt;
    logic [QPtrW-1:0]   n_wr;
    logic [QPtrW-1:0]   n_rd;
    logic [QCntW-1:0]   n_cnt;

    assign o_room  = r_cnt <= QCntW'(QDepth - 2);
    assign o_valid = r_cnt != '0;
    assign o_tok   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr + QPtrW'(i_push.cnt);
        n_rd  = r_rd + QPtrW'(i_pop);
        n_cnt = r_cnt + QCntW'(i_push.cnt) - QCntW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wr] <= i_push.tok0;
        if (i_push.cnt == 2'd2) r_mem[r_wr + QPtrW'(1)] <= i_push.tok1;
    end

endmodule

/* design/clx_back.sv */
// Back end: output register that presents one token per transfer.
module clx_back
    import clx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_token     i_tok,
    output logic       o_pop,
    clx_out_if.source  o_out
);

    logic   r_valid;
    t_token r_tok;

    // load whenever the register is empty or its token leaves this cycle
    assign o_pop = i_valid && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_out.ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_tok <= i_tok;
    end

    assign o_out.valid        = r_valid;
    assign o_out.token_kind   = r_tok.kind;
    assign o_out.start_offset = r_tok.start;
    assign o_out.last_of_run  = r_tok.last;

endmodule

/* design/config_text_lexer.sv */
// Top level of the configuration text lexer.
//
//  channel  | dir | payload                                   | handshake
//  i_in     | in  | data_byte[7:0], end_of_text               | valid/ready
//  o_out    | out | token_kind[3:0], start_offset[15:0],      | valid/ready
//           |     | last_of_run                               |
//
// One byte per cycle unless ready is low; tokens go through the queue, then the output register.
// A byte that yields two tokens needs two output transfers; the four-entry token queue absorbs that.
// i_in.ready drops while the queue holds more than two tokens, so stalls on o_out reach i_in.
// Reset (i_rst_n low at a clock edge) clears the lexer state, the queue and the output register.
module config_text_lexer
    import clx_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clx_in_if.sink     i_in,
    clx_out_if.source  o_out
);

    t_push  push;
    logic   room;
    logic   q_valid;
    t_token q_tok;
    logic   pop;

    clx_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (room),
        .o_push  (push)
    );

    clx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (q_valid),
        .o_tok   (q_tok),
        .i_pop   (pop)
    );

    clx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_tok   (q_tok),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

/* bench/config_text_lexer_tb.sv */
// Self-checking bench for config_text_lexer: directed probes, random text, a full-rate stretch.
module config_text_lexer_tb
    import clx_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT  = 600_000;
    localparam int          RANDOM_BYTES = 1080;
    localparam int          DRAIN_CYCLES = 16;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [31:0] WORD_TRUE    = "true";
    localparam logic [39:0] WORD_FALSE   = "false";

    typedef struct packed {
        logic [7:0] b;
        logic       eot;
    } t_text_char;

    typedef struct {
        logic [7:0]  b;
        logic        eot;
        bit          typed;
        int          n;
        t_tok_kind   k0;
        logic [15:0] s0;
        t_tok_kind   k1;
        logic [15:0] s1;
    } t_probe_row;

    logic i_clk;
    logic i_rst_n;

    clx_in_if  in_if();
    clx_out_if out_if();

    config_text_lexer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Lexer state as the bench sees it
    logic        lx_num_mode;
    t_pend       lx_pend;
    logic [15:0] lx_pend_start;
    logic [2:0]  lx_kw_seen;
    logic [1:0]  lx_kw_alive;
    logic [15:0] lx_pos;

    t_token      step_toks[$];
    t_token      tokens_due[$];
    t_text_char  text_bytes[$];

    int          mismatches;
    int          cycle_count;
    int          in_mode;
    int          out_mode;
    bit          full_rate;

    string kw_words [8] = '{"true", "false", "tru", "fals", "truest", "falsey",
                            "True", "fAlse"};

    // Offsets follow from the row index; the directed text ends with end of text.
    t_probe_row probe_rows [25] = '{
        '{ChEqual,   1'b0, 1'b1, 1, TK_EQUAL,    16'd0,  TK_INVALID, 16'd0},
        '{ChLBrace,  1'b0, 1'b1, 1, TK_LBRACE,   16'd1,  TK_INVALID, 16'd0},
        '{ChRBrace,  1'b0, 1'b1, 1, TK_RBRACE,   16'd2,  TK_INVALID, 16'd0},
        '{ChLBrack,  1'b0, 1'b1, 1, TK_LBRACKET, 16'd3,  TK_INVALID, 16'd0},
        '{ChRBrack,  1'b0, 1'b1, 1, TK_RBRACKET, 16'd4,  TK_INVALID, 16'd0},
        '{8'h00,     1'b0, 1'b1, 0, TK_INVALID,  16'd0,  TK_INVALID, 16'd0},
        '{ChDot,     1'b0, 1'b1, 1, TK_INVALID,  16'd6,  TK_INVALID, 16'd0},
        '{"9",       1'b0, 1'b1, 1, TK_NUMBER,   16'd7,  TK_INVALID, 16'd0},
        '{ChDot,     1'b0, 1'b1, 0, TK_INVALID,  16'd0,  TK_INVALID, 16'd0},
        '{ChNewline, 1'b0, 1'b1, 1, TK_NEWLINE,  16'd9,  TK_INVALID, 16'd0},
        '{ChDash,    1'b0, 1'b1, 0, TK_INVALID,  16'd0,  TK_INVALID, 16'd0},
        '{"0",       1'b0, 1'b1, 1, TK_NUMBER,   16'd10, TK_INVALID, 16'd0},
        '{ChDash,    1'b0, 1'b1, 0, TK_INVALID,  16'd0,  TK_INVALID, 16'd0},
        '{8'hFF,     1'b0, 1'b1, 1, TK_INVALID,  16'd12, TK_INVALID, 16'd0},
        '{"f",       1'b0, 1'b0, 0, TK_INVALID,  16'd0,  TK_INVALID, 16'd0},
        '{"a",       1'b0, 1'b0, 0, TK_INVALID,  16'd0,  TK_INVALID, 16'd0},
        '{"l",       1'b0, 1'b0, 0, TK_INVALID,  16'd0,  TK_INVALID, 16'd0},
        '{"s",       1'b0, 1'b0, 0, TK_INVALID,  16'd0,  TK_INVALID, 16'd0},
        '{"e",       1'b0, 1'b0, 0, TK_INVALID,  16'd0,  TK_INVALID, 16'd0},
        '{ChQuote,   1'b0, 1'b0, 0, TK_INVALID,  16'd0,  TK_INVALID, 16'd0},
        '{"Z",       1'b0, 1'b0, 0, TK_INVALID,  16'd0,  TK_INVALID, 16'd0},
        '{ChQuote,   1'b0, 1'b0, 0, TK_INVALID,  16'd0,  TK_INVALID, 16'd0},
        '{ChQuote,   1'b0, 1'b0, 0, TK_INVALID,  16'd0,  TK_INVALID, 16'd0},
        '{ChEqual,   1'b0, 1'b1, 2, TK_INVALID,  16'd22, TK_EQUAL,   16'd23},
        '{"q",       1'b1, 1'b1, 1, TK_IDENT,    16'd24, TK_INVALID, 16'd0}
    };

    // ---------------------------------------------------------------- predictor

    function automatic bit letter_byte(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic bit is_num(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic void lexer_clear();
        lx_num_mode   = 1'b0;
        lx_pend       = PK_NONE;
        lx_pend_start = '0;
        lx_kw_seen    = '0;
        lx_kw_alive   = 2'b11;
        lx_pos        = '0;
    endfunction

    // Drop keyword candidates that this letter rules out
    function automatic void note_letter(input logic [7:0] b);
        int k;
        k = lx_kw_seen;
        if (k < 4 && b != WORD_TRUE[31 - 8*k -: 8]) lx_kw_alive[0] = 1'b0;
        if (k < 5 && b != WORD_FALSE[39 - 8*k -: 8]) lx_kw_alive[1] = 1'b0;
        if (k < 5) lx_kw_seen = lx_kw_seen + 3'd1;
    endfunction

    function automatic t_tok_kind word_kind();
        if (lx_kw_alive[0] && lx_kw_seen >= 3'd4) return TK_TRUE;
        if (lx_kw_alive[1] && lx_kw_seen >= 3'd5) return TK_FALSE;
        return TK_IDENT;
    endfunction

    function automatic void give_token(input t_tok_kind k, input logic [15:0] s);
        if (step_toks.size() < 2) step_toks.push_back('{kind: k, start: s, last: 1'b0});
    endfunction

    // Work out the tokens one accepted byte causes and advance the state
    function automatic void lex_byte(input logic [7:0] b, input logic eot);
        bit          fresh;
        logic [15:0] here;
        t_token      t;
        step_toks = {};
        fresh = 1'b1;
        here  = lx_pos;
        case (lx_pend)
            PK_RUN: begin
                if (letter_byte(b)) begin
                    note_letter(b);
                    fresh = 1'b0;
                end else begin
                    give_token(word_kind(), lx_pend_start);
                    lx_pend = PK_NONE;
                end
            end
            PK_QUOTE: begin
                if (letter_byte(b) || is_num(b) || b == ChSpace) begin
                    fresh = 1'b0;
                end else if (b == ChQuote) begin
                    give_token(TK_IDENT, lx_pend_start);
                    lx_pend = PK_NONE;
                    fresh   = 1'b0;
                end else begin
                    give_token(TK_INVALID, lx_pend_start);
                    lx_pend = PK_NONE;
                end
            end
            PK_DASH: begin
                if (is_num(b)) begin
                    give_token(TK_NUMBER, lx_pend_start);
                    lx_num_mode = 1'b1;
                    fresh       = 1'b0;
                end else begin
                    give_token(TK_INVALID, lx_pend_start);
                end
                lx_pend = PK_NONE;
            end
            default: ;
        endcase

        if (fresh) begin
            if (letter_byte(b)) begin
                lx_pend       = PK_RUN;
                lx_pend_start = here;
                lx_kw_seen    = '0;
                lx_kw_alive   = 2'b11;
                note_letter(b);
            end else if (is_num(b)) begin
                if (!lx_num_mode) begin
                    give_token(TK_NUMBER, here);
                    lx_num_mode = 1'b1;
                end
            end else begin
                case (b)
                    ChDot:    if (!lx_num_mode) give_token(TK_INVALID, here);
                    ChDash: begin
                        lx_pend       = PK_DASH;
                        lx_pend_start = here;
                    end
                    ChQuote: begin
                        lx_pend       = PK_QUOTE;
                        lx_pend_start = here;
                    end
                    ChEqual:  give_token(TK_EQUAL, here);
                    ChLBrace: give_token(TK_LBRACE, here);
                    ChRBrace: give_token(TK_RBRACE, here);
                    ChLBrack: give_token(TK_LBRACKET, here);
                    ChRBrack: give_token(TK_RBRACKET, here);
                    ChNewline: begin
                        lx_num_mode = 1'b0;
                        give_token(TK_NEWLINE, here);
                    end
                    default: ;
                endcase
            end
        end

        if (eot) begin
            // flush whatever is still open, then start a new text at offset zero
            if (lx_pend == PK_RUN) give_token(word_kind(), lx_pend_start);
            else if (lx_pend != PK_NONE) give_token(TK_INVALID, lx_pend_start);
            lexer_clear();
        end else if (lx_pos != POS_MAX) begin
            lx_pos = lx_pos + 16'd1;
        end

        if (step_toks.size() > 0) begin
            t = step_toks.pop_back();
            t.last = 1'b1;
            step_toks.push_back(t);
        end
    endfunction

    // ---------------------------------------------------------------- text generation

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 3) == 0) c = c - 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic void append_char(input logic [7:0] b);
        text_bytes.push_back('{b: b, eot: 1'b0});
    endfunction

    function automatic void mark_eot();
        t_text_char c;
        c = text_bytes.pop_back();
        c.eot = 1'b1;
        text_bytes.push_back(c);
    endfunction

    // Append one well-formed lexeme, a broken one now and then, or noise
    function automatic void add_piece(input bit eot_ok);
        int    n;
        string w;
        case ($urandom_range(0, 21))
            0, 1, 2: begin
                n = $urandom_range(1, 8);
                repeat (n) append_char(rand_letter());
            end
            3, 4: begin
                w = kw_words[$urandom_range(0, 7)];
                for (int i = 0; i < w.len(); i++) append_char(w[i]);
            end
            5, 6: begin
                if ($urandom_range(0, 2) == 0) append_char(ChDash);
                n = $urandom_range(1, 4);
                repeat (n) append_char(rand_digit());
                if ($urandom_range(0, 3) == 0) begin
                    append_char(ChDot);
                    append_char(rand_digit());
                end
            end
            7, 8: begin
                append_char(ChQuote);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    case ($urandom_range(0, 2))
                        0:       append_char(rand_letter());
                        1:       append_char(rand_digit());
                        default: append_char(ChSpace);
                    endcase
                end
                // leave some quotes open so the next byte has to end them
                if ($urandom_range(0, 4) != 0) append_char(ChQuote);
            end
            9, 10, 11: begin
                case ($urandom_range(0, 4))
                    0:       append_char(ChEqual);
                    1:       append_char(ChLBrace);
                    2:       append_char(ChRBrace);
                    3:       append_char(ChLBrack);
                    default: append_char(ChRBrack);
                endcase
            end
            12, 13, 14: append_char(ChNewline);
            15, 16: begin
                n = $urandom_range(1, 3);
                repeat (n) append_char($urandom_range(0, 1) ? ChSpace : CH_TAB);
            end
            17: append_char(ChDot);
            18: append_char(ChDash);
            19: append_char(8'($urandom_range(0, 255)));
            default: append_char(ChSpace);
        endcase
        if (eot_ok && $urandom_range(0, 24) == 0) mark_eot();
    endfunction

    function automatic int draw_wait(input int mode);
        case (mode)
            0:       return 0;
            1:       return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    // ---------------------------------------------------------------- byte channel

    task automatic offer_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = draw_wait(in_mode);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.data_byte   <= b;
        in_if.end_of_text <= eot;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
    endtask

    task automatic feed(input logic [7:0] b, input logic eot);
        offer_byte(b, eot);
        lex_byte(b, eot);
        foreach (step_toks[j]) tokens_due.push_back(step_toks[j]);
    endtask

    // Hold the byte channel idle until every due token has been seen
    task automatic wait_tokens_out();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (tokens_due.size() != 0);
    endtask

    // ---------------------------------------------------------------- clock, reset, watchdog

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d tokens still due",
                 $time, cycle_count, tokens_due.size());
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- token channel

    initial begin
        t_token want;
        int     seen;
        int     stall;
        seen = 0;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (full_rate) out_mode = 0;
            else if (seen % 40 == 0) out_mode = $urandom_range(0, 2);
            stall = draw_wait(out_mode);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            seen++;
            if (tokens_due.size() == 0) begin
                mismatches++;
                $display("%0t: token with none due: kind %0d start %0d last %0b",
                         $time, out_if.token_kind, out_if.start_offset,
                         out_if.last_of_run);
            end else begin
                want = tokens_due.pop_front();
                if (out_if.token_kind !== want.kind) begin
                    mismatches++;
                    $display("%0t: token_kind expected %0d got %0d",
                             $time, want.kind, out_if.token_kind);
                end
                if (out_if.start_offset !== want.start) begin
                    mismatches++;
                    $display("%0t: start_offset expected %0d got %0d",
                             $time, want.start, out_if.start_offset);
                end
                if (out_if.last_of_run !== want.last) begin
                    mismatches++;
                    $display("%0t: last_of_run expected %0b got %0b",
                             $time, want.last, out_if.last_of_run);
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        t_probe_row row;
        mismatches        = 0;
        full_rate         = 1'b0;
        in_mode           = 2;
        in_if.valid       <= 1'b0;
        in_if.data_byte   <= '0;
        in_if.end_of_text <= 1'b0;
        i_rst_n           <= 1'b0;
        lexer_clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed probes: typed rows carry their own expectation
        foreach (probe_rows[i]) begin
            row = probe_rows[i];
            offer_byte(row.b, row.eot);
            lex_byte(row.b, row.eot);
            if (row.typed) begin
                if (row.n > 0)
                    tokens_due.push_back('{kind: row.k0, start: row.s0, last: row.n == 1});
                if (row.n > 1)
                    tokens_due.push_back('{kind: row.k1, start: row.s1, last: 1'b1});
            end else begin
                foreach (step_toks[j]) tokens_due.push_back(step_toks[j]);
            end
        end
        wait_tokens_out();

        // random text, idling redrawn in stretches, one full drain halfway
        text_bytes = {};
        while (text_bytes.size() < RANDOM_BYTES) add_piece(1'b1);
        if (!text_bytes[$].eot) mark_eot();
        for (int i = 0; i < text_bytes.size(); i++) begin
            if (i % 50 == 0) in_mode = $urandom_range(0, 2);
            if (i == text_bytes.size() / 2) wait_tokens_out();
            feed(text_bytes[i].b, text_bytes[i].eot);
        end

        // one short text with both sides at full rate
        full_rate = 1'b1;
        in_mode   = 0;
        text_bytes = {};
        while (text_bytes.size() < 40) add_piece(1'b0);
        mark_eot();
        foreach (text_bytes[i]) feed(text_bytes[i].b, text_bytes[i].eot);

        wait_tokens_out();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && tokens_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
